@@ design/mpq_pkg.sv @@
// Package with the constants, types and codes shared across the priority queue.
`timescale 1ns / 1ps
package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd9999;

    typedef logic signed [31:0] value_t;
    typedef logic [CNT_W-1:0] count_t;

    // Command broadcast to every cell of the row in a cycle.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

@@ design/mpq_if.sv @@
// Request and response channel interfaces of the priority queue.
`timescale 1ns / 1ps
interface mpq_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic signed [31:0] value_in;

    modport source (output valid, output req_type, output value_in, input ready);
    modport sink (input valid, input req_type, input value_in, output ready);
endinterface

interface mpq_rsp_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic signed [31:0] value_out;
    logic [4:0] occupancy;

    modport source (output valid, output status, output value_out, output occupancy,
                    input ready);
    modport sink (input valid, input status, input value_out, input occupancy,
                  output ready);
endinterface

@@ design/mpq_cell.sv @@
// One slot of the sorted row: keeps its value, shifts with its neighbors.
`timescale 1ns / 1ps
module mpq_cell (
    input  logic               clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::value_t    new_value,
    input  logic               occupied,
    input  mpq_pkg::value_t    left_value,
    input  logic               left_greater,
    input  mpq_pkg::value_t    right_value,
    output mpq_pkg::value_t    entry,
    output logic               greater
);

    mpq_pkg::value_t entry_reg;
    mpq_pkg::value_t entry_next;

    // Cells holding a value at least as large as the new one form a prefix of the row.
    assign greater = occupied && (entry_reg >= new_value);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (greater)
            begin
                entry_next = entry_reg;
            end
            else if (left_greater)
            begin
                entry_next = new_value;
            end
            else
            begin
                entry_next = left_value;
            end
        end
        else if (ctrl.rem)
        begin
            entry_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ design/max_priority_queue_unit.sv @@
// Top level of the bounded max-first priority queue built as a row of cells.
//
// Usage: requests arrive on the req channel as one word each (req_type 0 inserts
// value_in, req_type 1 removes the largest value held). Each request yields
// exactly one word on the rsp channel with status, value_out and occupancy.
// The values live in a row of CAPACITY cells kept in descending order, the
// largest in cell 0. On insert every cell compares itself with the new value
// in parallel and either holds, takes the new value or takes its left
// neighbor's value; on remove every cell takes its right neighbor's value.
// An accepted request has its response word in the output register in the
// next cycle. Throughput is one request per cycle while the receiver keeps
// up, set by the registered cell row update and one-entry output register.
// When the receiver stalls, the response is held and req.ready drops until
// that response is taken; a new request is accepted in the same cycle the
// pending response leaves. Reset clears the count and the output valid flag;
// cell contents are not cleared, since only occupied cells are ever read.
// A remove on an empty queue returns status empty and -9999; an insert on a
// full queue returns status full and drops the value.
`timescale 1ns / 1ps
module max_priority_queue_unit (
    input  logic      clk,
    input  logic      rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);

    localparam int N = mpq_pkg::CAPACITY;

    mpq_pkg::count_t count_reg;
    mpq_pkg::count_t count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    mpq_pkg::value_t value_reg;
    mpq_pkg::value_t value_next;
    mpq_pkg::count_t occ_reg;

    logic                take;
    logic                is_empty;
    logic                is_full;
    mpq_pkg::cell_ctrl_t ctrl;
    mpq_pkg::value_t     entries [N];
    logic                greaters [N];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == mpq_pkg::count_t'(N));

    assign ctrl.ins = take && (req.req_type == mpq_pkg::REQ_INSERT) && !is_full;
    assign ctrl.rem = take && (req.req_type == mpq_pkg::REQ_REMOVE) && !is_empty;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        mpq_pkg::value_t left_value;
        logic            left_greater;
        mpq_pkg::value_t right_value;
        logic            occupied;

        assign occupied = (mpq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            // Cell 0 sees an unbounded left neighbor, so it takes the new value
            // whenever it is not at least as large itself.
            assign left_value   = req.value_in;
            assign left_greater = 1'b1;
        end
        else
        begin : g_mid
            assign left_value   = entries[i-1];
            assign left_greater = greaters[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign right_value = entries[i];
        end
        else
        begin : g_inner
            assign right_value = entries[i+1];
        end

        mpq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .new_value    (req.value_in),
            .occupied     (occupied),
            .left_value   (left_value),
            .left_greater (left_greater),
            .right_value  (right_value),
            .entry        (entries[i]),
            .greater      (greaters[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (take)
        begin
            rsp_valid_next = 1'b1;
            if (req.req_type == mpq_pkg::REQ_INSERT)
            begin
                value_next = '0;
                if (is_full)
                begin
                    status_next = mpq_pkg::STATUS_FULL;
                end
                else
                begin
                    status_next = mpq_pkg::STATUS_OK;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = mpq_pkg::STATUS_EMPTY;
                    value_next  = mpq_pkg::EMPTY_VALUE;
                end
                else
                begin
                    status_next = mpq_pkg::STATUS_OK;
                    value_next  = entries[0];
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        if (take)
        begin
            occ_reg <= count_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_reg;
    assign rsp.occupancy = 5'(occ_reg);

endmodule
